@@ sv/radial_undistort_remap_defines.svh @@
// assertion macros for the radial undistort remap block
`ifndef RADIAL_UNDISTORT_REMAP_DEFINES_SVH
`define RADIAL_UNDISTORT_REMAP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define RUR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rur check failed: %m");

// condition holds on every cycle out of reset
`define RUR_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("rur check failed: %m");

`endif

@@ sv/rur_pkg.sv @@
package rur_pkg;

  localparam int unsigned DEF_FRAME_COLS = 1024;
  localparam int unsigned DEF_FRAME_ROWS = 1024;

  localparam int unsigned PIX_W      = 10;
  localparam int unsigned GREY_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // accept to result strobe, in clock edges
  localparam int unsigned LATENCY = 13;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_K1,
    REG_K2,
    REG_FX,
    REG_FY,
    REG_CX,
    REG_CY,
    REG_RFX,
    REG_RFY
  } reg_idx_t;

  localparam logic signed [17:0] K1_RST  = -18'sd18573;
  localparam logic signed [17:0] K2_RST  = 18'sd4847;
  localparam logic [19:0]        FX_RST  = 20'd117415;
  localparam logic [19:0]        FY_RST  = 20'd117068;
  localparam logic [19:0]        CX_RST  = 20'd94007;
  localparam logic [19:0]        CY_RST  = 20'd63584;
  localparam logic [23:0]        RFX_RST = 24'd36579;
  localparam logic [23:0]        RFY_RST = 24'd36688;

  typedef struct packed {
    logic signed [17:0] k1;
    logic signed [17:0] k2;
    logic [19:0]        fx;
    logic [19:0]        fy;
    logic [19:0]        cx;
    logic [19:0]        cy;
    logic [23:0]        rfx;
    logic [23:0]        rfy;
  } cfg_t;

  typedef struct packed {
    logic              rd;
    logic              wr_ok;
    logic [PIX_W-1:0]  col;
    logic [PIX_W-1:0]  row;
    logic [GREY_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic in_frame;
  } store_ctl_t;

endpackage

@@ sv/radial_undistort_remap.sv @@
// Radial undistort remap: takes one command word per clock. A write word stores a grey
// pixel; a read word names an output pixel and, after it is taken, produces one result
// on the out_ ports marked by out_strobe for a single cycle. The result passes through
// the command register, the command queue, the 10-stage mapping pipeline and the
// registered frame-store read. Writes travel the same pipeline and reach the store in
// command order, so a read always sees every earlier write. The frame store is one
// single-port memory of 2^(clog2(FRAME_COLS)+clog2(FRAME_ROWS)) bytes with no clearing
// after reset; a read of a pixel never written returns an undefined grey value. busy
// rises only if the queue fills, which the pipeline never lets happen. Configuration
// registers may be written only while no command is in flight.
module radial_undistort_remap
  import rur_pkg::*;
#(
  parameter int unsigned FRAME_COLS = DEF_FRAME_COLS,
  parameter int unsigned FRAME_ROWS = DEF_FRAME_ROWS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_command,
  input  logic [PIX_W-1:0]      in_pixel_col,
  input  logic [PIX_W-1:0]      in_pixel_row,
  input  logic [GREY_W-1:0]     in_pixel_value,
  output logic                  out_strobe,
  output logic [GREY_W-1:0]     out_grey_out,
  output logic                  out_source_inside,
  output logic [PIX_W-1:0]      out_source_col,
  output logic [PIX_W-1:0]      out_source_row,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned ADDR_W = $clog2(FRAME_COLS) + $clog2(FRAME_ROWS);

  cfg_t              cfg_r;
  logic              q_full;
  logic              q_empty;
  logic              push;
  logic              pop;
  item_t             push_item;
  item_t             head;
  store_ctl_t        req;
  logic [ADDR_W-1:0] addr;
  logic [GREY_W-1:0] wdata;
  logic [PIX_W-1:0]  src_col, src_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.k1  <= K1_RST;
      cfg_r.k2  <= K2_RST;
      cfg_r.fx  <= FX_RST;
      cfg_r.fy  <= FY_RST;
      cfg_r.cx  <= CX_RST;
      cfg_r.cy  <= CY_RST;
      cfg_r.rfx <= RFX_RST;
      cfg_r.rfy <= RFY_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_K1:  cfg_r.k1  <= $signed(cfg_wdata[17:0]);
        REG_K2:  cfg_r.k2  <= $signed(cfg_wdata[17:0]);
        REG_FX:  cfg_r.fx  <= cfg_wdata[19:0];
        REG_FY:  cfg_r.fy  <= cfg_wdata[19:0];
        REG_CX:  cfg_r.cx  <= cfg_wdata[19:0];
        REG_CY:  cfg_r.cy  <= cfg_wdata[19:0];
        REG_RFX: cfg_r.rfx <= cfg_wdata;
        REG_RFY: cfg_r.rfy <= cfg_wdata;
      endcase
    end
  end

  // back end takes a word whenever one is queued
  assign pop = !q_empty;

  rur_front #(
    .FRAME_COLS(FRAME_COLS),
    .FRAME_ROWS(FRAME_ROWS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_pixel_col  (in_pixel_col),
    .in_pixel_row  (in_pixel_row),
    .in_pixel_value(in_pixel_value),
    .q_full        (q_full),
    .push          (push),
    .push_item     (push_item)
  );

  rur_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  rur_map #(
    .FRAME_COLS(FRAME_COLS),
    .FRAME_ROWS(FRAME_ROWS)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_valid(pop),
    .in_item (head),
    .req     (req),
    .addr    (addr),
    .wdata   (wdata),
    .src_col (src_col),
    .src_row (src_row)
  );

  rur_store #(
    .FRAME_COLS(FRAME_COLS),
    .FRAME_ROWS(FRAME_ROWS)
  ) u_store (
    .clk              (clk),
    .rst_n            (rst_n),
    .req              (req),
    .addr             (addr),
    .wdata            (wdata),
    .src_col          (src_col),
    .src_row          (src_row),
    .out_strobe       (out_strobe),
    .out_grey_out     (out_grey_out),
    .out_source_inside(out_source_inside),
    .out_source_col   (out_source_col),
    .out_source_row   (out_source_row)
  );

endmodule

@@ sv/rur_front.sv @@
module rur_front
  import rur_pkg::*;
#(
  parameter int unsigned FRAME_COLS = DEF_FRAME_COLS,
  parameter int unsigned FRAME_ROWS = DEF_FRAME_ROWS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_command,
  input  logic [PIX_W-1:0]  in_pixel_col,
  input  logic [PIX_W-1:0]  in_pixel_row,
  input  logic [GREY_W-1:0] in_pixel_value,
  input  logic              q_full,
  output logic              push,
  output item_t             push_item
);

  logic  vld_r;
  item_t itm_r;
  logic  accept;

  assign busy      = vld_r && q_full;
  assign push      = vld_r && !q_full;
  assign accept    = start && !busy;
  assign push_item = itm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= accept || (vld_r && !push);
    end
  end

  // classify: read or write, and whether a write lands in the frame
  always_ff @(posedge clk) begin
    if (accept) begin
      itm_r.rd    <= (in_command == CMD_READ);
      itm_r.wr_ok <= ({1'b0, in_pixel_col} < (PIX_W+1)'(FRAME_COLS)) &&
                     ({1'b0, in_pixel_row} < (PIX_W+1)'(FRAME_ROWS));
      itm_r.col   <= in_pixel_col;
      itm_r.row   <= in_pixel_row;
      itm_r.value <= in_pixel_value;
    end
  end

endmodule

@@ sv/rur_queue.sv @@
module rur_queue
  import rur_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  empty,
  output logic  full
);

  item_t               slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp_r;
  logic [QUEUE_AW-1:0] rp_r;
  logic [QUEUE_AW:0]   cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end
  end

endmodule

@@ sv/rur_map.sv @@
module rur_map
  import rur_pkg::*;
#(
  parameter int unsigned FRAME_COLS = DEF_FRAME_COLS,
  parameter int unsigned FRAME_ROWS = DEF_FRAME_ROWS,
  localparam int unsigned COL_AW = $clog2(FRAME_COLS),
  localparam int unsigned ROW_AW = $clog2(FRAME_ROWS),
  localparam int unsigned ADDR_W = COL_AW + ROW_AW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  input  item_t             in_item,
  output store_ctl_t        req,
  output logic [ADDR_W-1:0] addr,
  output logic [GREY_W-1:0] wdata,
  output logic [PIX_W-1:0]  src_col,
  output logic [PIX_W-1:0]  src_row
);

  localparam logic signed [40:0] ONE_Q24 = 41'sd16777216;

  // (p >>> 8) clamped to [-2^28, 2^28-1]
  function automatic logic signed [28:0] sat_norm(input logic signed [45:0] p);
    logic signed [28:0] res;
    if (p[45:36] == {10{p[45]}}) begin
      res = p[36:8];
    end else if (p[45]) begin
      res = {1'b1, 28'd0};
    end else begin
      res = {1'b0, {28{1'b1}}};
    end
    return res;
  endfunction

  // clamp to [-2^30, 2^30-1]
  function automatic logic signed [30:0] sat_factor(input logic signed [40:0] s);
    logic signed [30:0] res;
    if (s[40:30] == {11{s[40]}}) begin
      res = s[30:0];
    end else if (s[40]) begin
      res = {1'b1, 30'd0};
    end else begin
      res = {1'b0, {30{1'b1}}};
    end
    return res;
  endfunction

  logic [9:1]         vld_r;
  item_t              itm_r [1:9];
  logic signed [45:0] px_r, py_r;
  logic signed [28:0] x_r [2:7];
  logic signed [28:0] y_r [2:7];
  logic [32:0]        xs_r, ys_r;
  logic [29:0]        r2_r;
  logic [35:0]        r4_r;
  logic signed [32:0] k1t_r, k1t6_r;
  logic signed [38:0] k2t_r;
  logic signed [30:0] f_r;
  logic signed [35:0] xd_r, yd_r;
  logic signed [32:0] tx_r, ty_r;

  store_ctl_t         req_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [GREY_W-1:0]  wdata_r;
  logic [PIX_W-1:0]   scol_r, srow_r;

  logic signed [20:0] dx, dy;
  logic signed [45:0] px_nxt, py_nxt;
  logic signed [57:0] xx, yy;
  logic [33:0]        sq_sum;
  logic [29:0]        r2_nxt;
  logic [59:0]        r4_full;
  logic signed [48:0] k1p;
  logic signed [54:0] k2p;
  logic signed [40:0] fsum;
  logic signed [59:0] xf, yf;
  logic signed [56:0] fxp, fyp;
  logic signed [33:0] ud, vd;
  logic [25:0]        scw, srw;
  logic               in_frame;

  // normalize
  assign dx     = $signed({3'b000, in_item.col, 8'h00}) - $signed({1'b0, cfg.cx});
  assign dy     = $signed({3'b000, in_item.row, 8'h00}) - $signed({1'b0, cfg.cy});
  assign px_nxt = dx * $signed({1'b0, cfg.rfx});
  assign py_nxt = dy * $signed({1'b0, cfg.rfy});

  // radius terms
  assign xx      = x_r[2] * x_r[2];
  assign yy      = y_r[2] * y_r[2];
  assign sq_sum  = {1'b0, xs_r} + {1'b0, ys_r};
  assign r2_nxt  = (|sq_sum[33:30]) ? {30{1'b1}} : sq_sum[29:0];
  assign r4_full = r2_r * r2_r;
  assign k1p     = $signed(cfg.k1) * $signed({1'b0, r2_r});
  assign k2p     = $signed(cfg.k2) * $signed({1'b0, r4_r});
  assign fsum    = ONE_Q24 + 41'(k1t6_r) + 41'(k2t_r);

  // distort and map back to pixels
  assign xf  = x_r[7] * f_r;
  assign yf  = y_r[7] * f_r;
  assign fxp = $signed({1'b0, cfg.fx}) * xd_r;
  assign fyp = $signed({1'b0, cfg.fy}) * yd_r;
  assign ud  = 34'(tx_r) + $signed({14'd0, cfg.cx});
  assign vd  = 34'(ty_r) + $signed({14'd0, cfg.cy});
  assign scw = ud[33:8];
  assign srw = vd[33:8];

  assign in_frame = !ud[33] && !vd[33] &&
                    (scw < 26'(FRAME_COLS)) && (srw < 26'(FRAME_ROWS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      req_r <= '0;
    end else begin
      vld_r          <= {vld_r[8:1], in_valid};
      req_r.rd       <= vld_r[9] && itm_r[9].rd;
      req_r.wr       <= vld_r[9] && !itm_r[9].rd && itm_r[9].wr_ok;
      req_r.in_frame <= in_frame;
    end
  end

  always_ff @(posedge clk) begin
    itm_r[1] <= in_item;
    for (int i = 2; i <= 9; i++) begin
      itm_r[i] <= itm_r[i-1];
    end
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    x_r[2] <= sat_norm(px_r);
    y_r[2] <= sat_norm(py_r);
    for (int i = 3; i <= 7; i++) begin
      x_r[i] <= x_r[i-1];
      y_r[i] <= y_r[i-1];
    end
    xs_r   <= xx[56:24];
    ys_r   <= yy[56:24];
    r2_r   <= r2_nxt;
    r4_r   <= r4_full[59:24];
    k1t_r  <= k1p[48:16];
    k1t6_r <= k1t_r;
    k2t_r  <= k2p[54:16];
    f_r    <= sat_factor(fsum);
    xd_r   <= xf[59:24];
    yd_r   <= yf[59:24];
    tx_r   <= fxp[56:24];
    ty_r   <= fyp[56:24];
    if (itm_r[9].rd) begin
      addr_r <= {srw[ROW_AW-1:0], scw[COL_AW-1:0]};
    end else begin
      addr_r <= {itm_r[9].row[ROW_AW-1:0], itm_r[9].col[COL_AW-1:0]};
    end
    wdata_r <= itm_r[9].value;
    scol_r  <= in_frame ? scw[PIX_W-1:0] : '0;
    srow_r  <= in_frame ? srw[PIX_W-1:0] : '0;
  end

  assign req     = req_r;
  assign addr    = addr_r;
  assign wdata   = wdata_r;
  assign src_col = scol_r;
  assign src_row = srow_r;

endmodule

@@ sv/rur_store.sv @@
module rur_store
  import rur_pkg::*;
#(
  parameter int unsigned FRAME_COLS = DEF_FRAME_COLS,
  parameter int unsigned FRAME_ROWS = DEF_FRAME_ROWS,
  localparam int unsigned ADDR_W = $clog2(FRAME_COLS) + $clog2(FRAME_ROWS),
  localparam int unsigned DEPTH  = 1 << ADDR_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  store_ctl_t        req,
  input  logic [ADDR_W-1:0] addr,
  input  logic [GREY_W-1:0] wdata,
  input  logic [PIX_W-1:0]  src_col,
  input  logic [PIX_W-1:0]  src_row,
  output logic              out_strobe,
  output logic [GREY_W-1:0] out_grey_out,
  output logic              out_source_inside,
  output logic [PIX_W-1:0]  out_source_col,
  output logic [PIX_W-1:0]  out_source_row
);

  logic [GREY_W-1:0] mem [DEPTH];
  logic [GREY_W-1:0] rdata_r;
  logic              strobe_r;
  logic              inside_r;
  logic [PIX_W-1:0]  col_r, row_r;

  // one port: a write word writes, a read word fetches
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= req.rd;
    end
  end

  always_ff @(posedge clk) begin
    inside_r <= req.in_frame;
    col_r    <= src_col;
    row_r    <= src_row;
  end

  assign out_strobe        = strobe_r;
  assign out_grey_out      = inside_r ? rdata_r : '0;
  assign out_source_inside = inside_r;
  assign out_source_col    = col_r;
  assign out_source_row    = row_r;

endmodule

@@ sv/rur_checker.sv @@
`include "radial_undistort_remap_defines.svh"

module rur_checker
  import rur_pkg::*;
#(
  parameter int unsigned FRAME_COLS = DEF_FRAME_COLS,
  parameter int unsigned FRAME_ROWS = DEF_FRAME_ROWS
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  in_command,
  input logic                  out_strobe,
  input logic [GREY_W-1:0]     out_grey_out,
  input logic                  out_source_inside,
  input logic [PIX_W-1:0]      out_source_col,
  input logic [PIX_W-1:0]      out_source_row
);

  // the queue always drains, so busy never rises
  `RUR_ASSERT_ALWAYS(a_never_busy, !busy)

  // every result comes from an earlier accepted read word
  `RUR_ASSERT_IMPL(a_result_from_read, out_strobe, $past(start && !busy && in_command, LATENCY))

  // an outside source zeroes the word
  `RUR_ASSERT_IMPL(a_outside_zero, out_strobe && !out_source_inside, (out_grey_out == '0) && (out_source_col == '0) && (out_source_row == '0))

  // an inside source lies within the frame
  `RUR_ASSERT_IMPL(a_inside_in_frame, out_strobe && out_source_inside, ({1'b0, out_source_col} < (PIX_W+1)'(FRAME_COLS)) && ({1'b0, out_source_row} < (PIX_W+1)'(FRAME_ROWS)))

endmodule

bind radial_undistort_remap rur_checker #(
  .FRAME_COLS(FRAME_COLS),
  .FRAME_ROWS(FRAME_ROWS)
) u_rur_checker (.*);
